>>> src/rgblab_pkg.sv
// ----------------------------------------------------------------------------
// rgblab_pkg
// Shared constants and tables for the RGB to l-alpha-beta converter.
// ----------------------------------------------------------------------------
package rgblab_pkg;

  // Default number of fraction bits in the results.
  localparam int FRAC_BITS_DEF = 12;

  // Raw LMS sums are below 2^24.
  localparam int LMS_W = 24;
  // Log2 values in Q16, at most 24 * 65536.
  localparam int LOG_W = 21;
  // Offset logs, signed.
  localparam int G_W = 22;

  localparam logic [LMS_W-1:0] LMS_FLOOR = 24'd1671;
  localparam logic [LOG_W-1:0] LOG_OFFSET = 21'd1572494;

  localparam logic [14:0] K_LUM = 15'd11390;
  localparam logic [14:0] K_ALPHA = 15'd8054;
  localparam logic [14:0] K_BETA = 15'd13950;

  // RGB-to-LMS coefficients, unsigned Q0.16; row is L, M, S; column r, g, b.
  typedef logic [15:0] coef_t;
  localparam coef_t MIX [3][3] = '{
    '{16'd24976, 16'd37899, 16'd2635},
    '{16'd12891, 16'd47474, 16'd5125},
    '{16'd1579, 16'd8441, 16'd55339}
  };

  // Log2 of 1 + k/16 in Q16.
  typedef logic [16:0] log_ent_t;
  localparam log_ent_t LOG2_TAB [17] = '{
    17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
    17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
    17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  // Fields handed from the normalize stage to the interpolate stage.
  typedef struct packed {
    logic [4:0]  expo;
    logic [3:0]  seg;
    logic [15:0] rem;
  } norm_t;

endpackage

>>> src/rgblab_log2.sv
// ----------------------------------------------------------------------------
// rgblab_log2
// Two-stage log2 in Q16 of a clamped LMS sum, less a fixed offset: normalize, then interpolate.
// ----------------------------------------------------------------------------
module rgblab_log2 import rgblab_pkg::*; (
  input  logic             clk,
  input  logic             en_a,
  input  logic             en_b,
  input  logic [LMS_W-1:0] x,
  output logic [G_W-1:0]   g
);

  norm_t norm_r;
  norm_t norm_nxt;
  logic [G_W-1:0] g_r;
  logic [G_W-1:0] g_nxt;

  // Find the top set bit and normalize the value.
  always_comb begin
    logic [LMS_W-1:0] xc;
    logic [4:0]       e;
    logic [31:0]      n;
    xc = (x < LMS_FLOOR) ? LMS_FLOOR : x;
    e = '0;
    for (int i = 0; i < LMS_W; i++) begin
      if (xc[i]) begin
        e = 5'(i);
      end
    end
    n = {8'd0, xc} << (5'd31 - e);
    norm_nxt.expo = e;
    norm_nxt.seg = n[30:27];
    norm_nxt.rem = n[26:11];
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      norm_r <= norm_nxt;
    end
  end

  // Interpolate between table entries and remove the scale offset.
  always_comb begin
    log_ent_t    lo;
    log_ent_t    hi;
    logic [16:0] diff;
    logic [32:0] prod;
    logic [LOG_W-1:0] lg;
    lo = LOG2_TAB[norm_r.seg];
    hi = LOG2_TAB[5'(norm_r.seg) + 5'd1];
    diff = hi - lo;
    prod = diff * norm_r.rem + 33'd32768;
    lg = {norm_r.expo, 16'd0} + LOG_W'(lo) + LOG_W'(prod[32:16]);
    g_nxt = G_W'(lg) - G_W'(LOG_OFFSET);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      g_r <= g_nxt;
    end
  end

  assign g = g_r;

endmodule

>>> src/rgblab_mix.sv
// ----------------------------------------------------------------------------
// rgblab_mix
// Final matrix: scale the log sums and round and saturate each result.
// ----------------------------------------------------------------------------
module rgblab_mix import rgblab_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en_a,
  input  logic                  en_b,
  input  logic signed [G_W-1:0] g_l,
  input  logic signed [G_W-1:0] g_m,
  input  logic signed [G_W-1:0] g_s,
  output logic signed [15:0]    lum,
  output logic signed [15:0]    alpha_ch,
  output logic signed [15:0]    beta_ch
);

  localparam int SH = 32 - FRAC_BITS;
  localparam int PW = G_W + 2 + 16;

  logic signed [PW-1:0] p_r [3];
  logic signed [PW-1:0] p_nxt [3];
  logic signed [15:0]   o_r [3];
  logic signed [15:0]   o_nxt [3];

  // Sums of logs times the matrix constants.
  always_comb begin
    logic signed [G_W+1:0] sl;
    logic signed [G_W+1:0] sa;
    logic signed [G_W+1:0] sb;
    sl = (G_W+2)'(g_l) + (G_W+2)'(g_m) + (G_W+2)'(g_s);
    sa = (G_W+2)'(g_l) + (G_W+2)'(g_m) - ((G_W+2)'(g_s) <<< 1);
    sb = (G_W+2)'(g_l) - (G_W+2)'(g_m);
    p_nxt[0] = PW'(sl) * PW'($signed({1'b0, K_LUM}));
    p_nxt[1] = PW'(sa) * PW'($signed({1'b0, K_ALPHA}));
    p_nxt[2] = PW'(sb) * PW'($signed({1'b0, K_BETA}));
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      p_r <= p_nxt;
    end
  end

  // Round half up, then saturate to 16 bits.
  always_comb begin
    logic signed [PW-1:0] v;
    for (int i = 0; i < 3; i++) begin
      v = (p_r[i] + (PW'(1) <<< (SH - 1))) >>> SH;
      if (v > PW'(32767)) begin
        o_nxt[i] = 16'sd32767;
      end else if (v < -PW'(32768)) begin
        o_nxt[i] = -16'sd32768;
      end else begin
        o_nxt[i] = v[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      o_r <= o_nxt;
    end
  end

  assign lum = o_r[0];
  assign alpha_ch = o_r[1];
  assign beta_ch = o_r[2];

endmodule

>>> src/rgb_to_lalphabeta_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_lalphabeta_convert
// Streaming RGB to l-alpha-beta converter, one pixel per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports                              Handshake
// in       input      in_blue, in_green, in_red          in_valid / in_stall
// out      output     out_lum, out_alpha_ch, out_beta_ch out_valid / out_stall
//
// Five register stages: LMS matrix, normalize, interpolate, matrix product,
// round and saturate into the output. One transaction is taken every cycle
// while the output is not stalled. A stall on the output freezes the whole
// pipeline; nothing is lost.
// Reset clears only the stage valid bits.
module rgb_to_lalphabeta_convert import rgblab_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_blue,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_red,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_lum,
  output logic signed [15:0] out_alpha_ch,
  output logic signed [15:0] out_beta_ch
);

  localparam int NST = 5;

  logic [NST-1:0]   vld_r;
  logic [NST-1:0]   vld_nxt;
  logic             adv;
  logic [LMS_W-1:0] lms_r [3];
  logic [LMS_W-1:0] lms_nxt [3];
  logic [G_W-1:0]   g [3];

  // The pipeline moves when the last stage is empty or being taken.
  assign adv = !(vld_r[NST-1] && out_stall);
  assign in_stall = !adv;

  assign vld_nxt = {vld_r[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // RGB to LMS matrix.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lms_nxt[i] = LMS_W'(MIX[i][0]) * LMS_W'(in_red)
                 + LMS_W'(MIX[i][1]) * LMS_W'(in_green)
                 + LMS_W'(MIX[i][2]) * LMS_W'(in_blue);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lms_r <= lms_nxt;
    end
  end

  // One log unit per LMS channel.
  for (genvar c = 0; c < 3; c++) begin : g_log
    rgblab_log2 u_log (
      .clk  (clk),
      .en_a (adv),
      .en_b (adv),
      .x    (lms_r[c]),
      .g    (g[c])
    );
  end

  rgblab_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk      (clk),
    .en_a     (adv),
    .en_b     (adv),
    .g_l      (g[0]),
    .g_m      (g[1]),
    .g_s      (g[2]),
    .lum      (out_lum),
    .alpha_ch (out_alpha_ch),
    .beta_ch  (out_beta_ch)
  );

  assign out_valid = vld_r[NST-1];

endmodule
